[rtl/impedance_command_frame_encoder_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the impedance command frame encoder
// Shared implication checks, sampled on the rising clock edge and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef IMPEDANCE_COMMAND_FRAME_ENCODER_MACROS_SVH
`define IMPEDANCE_COMMAND_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication: cond holds, so expr holds too.
`define ICFE_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("icfe: same-cycle check failed");

// Next-cycle implication: cond holds, so expr holds in the next cycle.
`define ICFE_ASSERT_NXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("icfe: next-cycle check failed");

`endif

[rtl/icfe_pkg.sv]
// ---------------------------------------------------------------------------
// icfe_pkg
// Request and response types, register indexes, limit and reciprocal
// constants for the impedance command frame encoder.
// ---------------------------------------------------------------------------
package icfe_pkg;

   // Request payload: one impedance command
   typedef struct packed {
      logic signed [17:0] pos_target;
      logic signed [15:0] vel_target;
      logic signed [15:0] stiffness;
      logic signed [15:0] damping;
      logic signed [15:0] torque_ff;
   } req_type;

   // Response payload: identifier and 8-byte frame
   typedef struct packed {
      logic [15:0] frame_id;
      logic [7:0]  byte_0;
      logic [7:0]  byte_1;
      logic [7:0]  byte_2;
      logic [7:0]  byte_3;
      logic [7:0]  byte_4;
      logic [7:0]  byte_5;
      logic [7:0]  byte_6;
      logic [7:0]  byte_7;
   } rsp_type;

   // Register indexes
   localparam logic [1:0] REG_MODEL_SELECT = 2'd0;
   localparam logic [1:0] REG_NODE_ID      = 2'd1;
   localparam logic [1:0] REG_MODE_CODE    = 2'd2;

   // Reset values
   localparam logic [1:0] MODEL_SELECT_RST = 2'd0;
   localparam logic [7:0] NODE_ID_RST      = 8'd1;
   localparam logic [7:0] MODE_CODE_RST    = 8'd8;

   // Motor model codes
   localparam logic [1:0] MODEL_0 = 2'd0;
   localparam logic [1:0] MODEL_1 = 2'd1;
   localparam logic [1:0] MODEL_2 = 2'd2;

   // Reciprocal fraction bits
   localparam int FRAC_BITS = 20;

   // Position: +-51446 for every model, 16-bit code
   localparam logic signed [17:0] POS_HI    = 18'sd51446;
   localparam logic signed [17:0] POS_LO    = -18'sd51446;
   localparam logic [16:0]        POS_SPAN  = 17'd102892;
   localparam logic [19:0]        POS_RECIP = 20'd667880;

   // Gains: 0..16000 and 0..20480, 12-bit codes
   localparam logic signed [15:0] KP_HI    = 16'sd16000;
   localparam logic [19:0]        KP_RECIP = 20'd268435;
   localparam logic signed [15:0] KD_HI    = 16'sd20480;
   localparam logic [19:0]        KD_RECIP = 20'd209715;

   // Velocity half-span per model (unused model code falls back to model 0)
   function automatic logic [14:0] vel_limit(input logic [1:0] model);
      logic [14:0] lim;
      unique case (model)
         MODEL_1: lim = 15'd7168;
         MODEL_2: lim = 15'd7680;
         default: lim = 15'd15360;
      endcase
      return lim;
   endfunction

   function automatic logic [19:0] vel_recip(input logic [1:0] model);
      logic [19:0] r;
      unique case (model)
         MODEL_1: r = 20'd299593;
         MODEL_2: r = 20'd279620;
         default: r = 20'd139810;
      endcase
      return r;
   endfunction

   // Torque half-span per model
   function automatic logic [14:0] trq_limit(input logic [1:0] model);
      logic [14:0] lim;
      unique case (model)
         MODEL_1: lim = 15'd13824;
         MODEL_2: lim = 15'd8192;
         default: lim = 15'd3072;
      endcase
      return lim;
   endfunction

   function automatic logic [19:0] trq_recip(input logic [1:0] model);
      logic [19:0] r;
      unique case (model)
         MODEL_1: r = 20'd155345;
         MODEL_2: r = 20'd262144;
         default: r = 20'd699051;
      endcase
      return r;
   endfunction

endpackage

[rtl/impedance_command_frame_encoder.sv]
// ---------------------------------------------------------------------------
// impedance_command_frame_encoder
// Clamps an impedance command to the selected motor limits, scales each
// value to an unsigned code by reciprocal multiply and packs the frame.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_stall  icfe_pkg::req_type
//   rsp      out  rsp_valid/rsp_stall  icfe_pkg::rsp_type
//   csr      in   csr_we               csr_index, csr_wdata
//
// One request per cycle while rsp is not stalled; stages clamp, multiply, pack.
// The five reciprocal multipliers in the middle stage set the clock period.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on rsp holds the output; stages behind it fill up before
// req_stall rises, so no request is dropped or repeated.
//
`include "impedance_command_frame_encoder_macros.svh"

module impedance_command_frame_encoder (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  icfe_pkg::req_type   req_data,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output icfe_pkg::rsp_type   rsp_data,
   // register write port
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata
);

   // Register file
   logic [1:0] model_ff;
   logic [7:0] node_id_ff;
   logic [7:0] mode_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff     <= icfe_pkg::MODEL_SELECT_RST;
         node_id_ff   <= icfe_pkg::NODE_ID_RST;
         mode_code_ff <= icfe_pkg::MODE_CODE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            icfe_pkg::REG_MODEL_SELECT: model_ff     <= csr_wdata[1:0];
            icfe_pkg::REG_NODE_ID:      node_id_ff   <= csr_wdata;
            icfe_pkg::REG_MODE_CODE:    mode_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when empty or when the next one loads
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: clamp and offset from the lower limit
   logic [16:0] off_pos_in, off_pos_ff;
   logic [14:0] off_vel_in, off_vel_ff;
   logic [13:0] off_kp_in,  off_kp_ff;
   logic [14:0] off_kd_in,  off_kd_ff;
   logic [14:0] off_trq_in, off_trq_ff;
   logic [1:0]  model1_ff;

   logic signed [16:0] vel_x, vel_l, trq_x, trq_l;
   logic signed [18:0] pos_sum;
   logic signed [16:0] vel_sum, trq_sum;

   always_comb begin
      vel_x   = 17'(req_data.vel_target);
      vel_l   = $signed({2'b00, icfe_pkg::vel_limit(model_ff)});
      trq_x   = 17'(req_data.torque_ff);
      trq_l   = $signed({2'b00, icfe_pkg::trq_limit(model_ff)});
      pos_sum = 19'(req_data.pos_target) + 19'(icfe_pkg::POS_HI);
      vel_sum = vel_x + vel_l;
      trq_sum = trq_x + trq_l;

      // position
      if (req_data.pos_target < icfe_pkg::POS_LO) off_pos_in = '0;
      else if (req_data.pos_target > icfe_pkg::POS_HI) off_pos_in = icfe_pkg::POS_SPAN;
      else off_pos_in = pos_sum[16:0];

      // velocity
      if (vel_x < -vel_l) off_vel_in = '0;
      else if (vel_x > vel_l) off_vel_in = {vel_l[13:0], 1'b0};
      else off_vel_in = vel_sum[14:0];

      // stiffness gain
      if (req_data.stiffness < 16'sd0) off_kp_in = '0;
      else if (req_data.stiffness > icfe_pkg::KP_HI) off_kp_in = icfe_pkg::KP_HI[13:0];
      else off_kp_in = req_data.stiffness[13:0];

      // damping gain
      if (req_data.damping < 16'sd0) off_kd_in = '0;
      else if (req_data.damping > icfe_pkg::KD_HI) off_kd_in = icfe_pkg::KD_HI[14:0];
      else off_kd_in = req_data.damping[14:0];

      // feed-forward torque
      if (trq_x < -trq_l) off_trq_in = '0;
      else if (trq_x > trq_l) off_trq_in = {trq_l[13:0], 1'b0};
      else off_trq_in = trq_sum[14:0];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         off_pos_ff <= off_pos_in;
         off_vel_ff <= off_vel_in;
         off_kp_ff  <= off_kp_in;
         off_kd_ff  <= off_kd_in;
         off_trq_ff <= off_trq_in;
         model1_ff  <= model_ff;
      end
   end

   // Stage 2: multiply by the reciprocal of the span
   logic [36:0] prod_pos_in, prod_pos_ff;
   logic [34:0] prod_vel_in, prod_vel_ff;
   logic [33:0] prod_kp_in,  prod_kp_ff;
   logic [34:0] prod_kd_in,  prod_kd_ff;
   logic [34:0] prod_trq_in, prod_trq_ff;

   assign prod_pos_in = 37'(off_pos_ff) * 37'(icfe_pkg::POS_RECIP);
   assign prod_vel_in = 35'(off_vel_ff) * 35'(icfe_pkg::vel_recip(model1_ff));
   assign prod_kp_in  = 34'(off_kp_ff)  * 34'(icfe_pkg::KP_RECIP);
   assign prod_kd_in  = 35'(off_kd_ff)  * 35'(icfe_pkg::KD_RECIP);
   assign prod_trq_in = 35'(off_trq_ff) * 35'(icfe_pkg::trq_recip(model1_ff));

   always_ff @(posedge clock) begin
      if (en2) begin
         prod_pos_ff <= prod_pos_in;
         prod_vel_ff <= prod_vel_in;
         prod_kp_ff  <= prod_kp_in;
         prod_kd_ff  <= prod_kd_in;
         prod_trq_ff <= prod_trq_in;
      end
   end

   // Stage 3: drop fraction bits, saturate at full scale, pack the frame
   logic [15:0] code_pos;
   logic [11:0] code_vel, code_kp, code_kd, code_trq;
   icfe_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      code_pos = (prod_pos_ff[36]) ? 16'hFFFF : prod_pos_ff[35:20];
      code_vel = (prod_vel_ff[34:32] != 3'd0) ? 12'hFFF : prod_vel_ff[31:20];
      code_kp  = (prod_kp_ff[33:32]  != 2'd0) ? 12'hFFF : prod_kp_ff[31:20];
      code_kd  = (prod_kd_ff[34:32]  != 3'd0) ? 12'hFFF : prod_kd_ff[31:20];
      code_trq = (prod_trq_ff[34:32] != 3'd0) ? 12'hFFF : prod_trq_ff[31:20];

      rsp_in.frame_id = {mode_code_ff, node_id_ff};
      rsp_in.byte_0   = code_kp[11:4];
      rsp_in.byte_1   = {code_kp[3:0], code_kd[11:8]};
      rsp_in.byte_2   = code_kd[7:0];
      rsp_in.byte_3   = code_pos[15:8];
      rsp_in.byte_4   = code_pos[7:0];
      rsp_in.byte_5   = code_vel[11:4];
      rsp_in.byte_6   = {code_vel[3:0], code_trq[11:8]};
      rsp_in.byte_7   = code_trq[7:0];
   end

   always_ff @(posedge clock) begin
      if (en3) rsp_ff <= rsp_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ICFE_ASSERT_NXT(a_entry_fills, clock, reset, req_valid && !req_stall, v1_ff)
   `ICFE_ASSERT_NXT(a_stage1_holds, clock, reset, v1_ff && !en2, v1_ff)
   `ICFE_ASSERT_NXT(a_stage2_moves, clock, reset, v2_ff && en3, v3_ff)
   `ICFE_ASSERT_IMP(a_pos_in_span, clock, reset, v1_ff, off_pos_ff <= icfe_pkg::POS_SPAN)
   `ICFE_ASSERT_IMP(a_kp_in_span, clock, reset, v1_ff,
                    off_kp_ff <= icfe_pkg::KP_HI[13:0])

endmodule

[dv/impedance_command_frame_encoder_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// impedance_command_frame_encoder_tb
// Self-checking bench for the impedance command frame encoder. A short table
// of corner-case commands runs first, then random commands under several
// register settings, including every model select and the id extremes.
// Each accepted request is scored by an in-bench encoder or by its table frame
// and compared field by field with the frame that comes out.
// ---------------------------------------------------------------------------
module impedance_command_frame_encoder_tb;

   // Scaling constants: limits and 20-bit fraction reciprocals
   localparam int          SCALE_POS_BOUND = 51446;
   localparam int unsigned SCALE_POS_RCP   = 667880;
   localparam int          SCALE_KP_MAX    = 16000;
   localparam int unsigned SCALE_KP_RCP    = 268435;
   localparam int          SCALE_KD_MAX    = 20480;
   localparam int unsigned SCALE_KD_RCP    = 209715;
   localparam int          RCP_SHIFT       = 20;

   localparam logic [1:0]  MODEL_SPARE     = 2'd3;
   localparam int          PHASE_COUNT     = 7;
   localparam int          PHASE_ITEMS     = 240;
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          TAIL_CYCLES     = 8;

   localparam icfe_pkg::rsp_type FRAME_RST_ZERO =
      {icfe_pkg::MODE_CODE_RST, icfe_pkg::NODE_ID_RST, 64'h0};
   localparam icfe_pkg::rsp_type FRAME_RST_FULL =
      {icfe_pkg::MODE_CODE_RST, icfe_pkg::NODE_ID_RST, 64'hFFFF_FFFF_FFFF_FFFF};

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC}
      stall_style_type;

   typedef struct {
      icfe_pkg::req_type cmd;
      bit                has_frame;
      icfe_pkg::rsp_type frame;
   } directed_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   icfe_pkg::req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   icfe_pkg::rsp_type rsp_data;
   logic    csr_we    = 1'b0;
   logic [1:0] csr_index = icfe_pkg::REG_MODEL_SELECT;
   logic [7:0] csr_wdata = '0;

   // Register mirror
   logic [1:0] cfg_model = icfe_pkg::MODEL_SELECT_RST;
   logic [7:0] cfg_node  = icfe_pkg::NODE_ID_RST;
   logic [7:0] cfg_mode  = icfe_pkg::MODE_CODE_RST;

   icfe_pkg::rsp_type frame_expect_q[$];
   directed_row_type  directed_rows[$];
   int            error_count    = 0;
   int            frames_checked = 0;
   int            cmds_sent      = 0;
   int            cycle_count    = 0;

   stall_style_type stall_style = STALL_NONE;
   int            stall_timer = 0;
   int            stall_tick  = 0;

   impedance_command_frame_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Per-model velocity and torque half spans with their reciprocals;
   // the spare model code falls back to model 0
   function automatic void model_limits(input logic [1:0] m,
                                        output int vel_h, output int unsigned vel_r,
                                        output int trq_h, output int unsigned trq_r);
      case (m)
         icfe_pkg::MODEL_1: begin
            vel_h = 7168;  vel_r = 299593;
            trq_h = 13824; trq_r = 155345;
         end
         icfe_pkg::MODEL_2: begin
            vel_h = 7680;  vel_r = 279620;
            trq_h = 8192;  trq_r = 262144;
         end
         default: begin
            vel_h = 15360; vel_r = 139810;
            trq_h = 3072;  trq_r = 699051;
         end
      endcase
   endfunction

   // Clamp, offset, reciprocal multiply, saturate at the top code
   function automatic logic [15:0] scale_to_code(int x, int lo, int hi,
                                                 int unsigned recip, int bits);
      longint prod;
      longint top;
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      prod = (longint'(x - lo) * longint'(recip)) >>> RCP_SHIFT;
      top  = (longint'(1) << bits) - 1;
      if (prod > top) prod = top;
      return prod[15:0];
   endfunction

   // Frame that the current register settings give for one command
   function automatic icfe_pkg::rsp_type encode_frame(icfe_pkg::req_type c);
      int          vel_h, trq_h;
      int unsigned vel_r, trq_r;
      logic [15:0] pc, vc, kpc, kdc, tc;
      icfe_pkg::rsp_type f;
      model_limits(cfg_model, vel_h, vel_r, trq_h, trq_r);
      pc  = scale_to_code(int'(c.pos_target), -SCALE_POS_BOUND, SCALE_POS_BOUND,
                          SCALE_POS_RCP, 16);
      vc  = scale_to_code(int'(c.vel_target), -vel_h, vel_h, vel_r, 12);
      kpc = scale_to_code(int'(c.stiffness), 0, SCALE_KP_MAX, SCALE_KP_RCP, 12);
      kdc = scale_to_code(int'(c.damping), 0, SCALE_KD_MAX, SCALE_KD_RCP, 12);
      tc  = scale_to_code(int'(c.torque_ff), -trq_h, trq_h, trq_r, 12);
      f.frame_id = {cfg_mode, cfg_node};
      f.byte_0   = kpc[11:4];
      f.byte_1   = {kpc[3:0], kdc[11:8]};
      f.byte_2   = kdc[7:0];
      f.byte_3   = pc[15:8];
      f.byte_4   = pc[7:0];
      f.byte_5   = vc[11:4];
      f.byte_6   = {vc[3:0], tc[11:8]};
      f.byte_7   = tc[7:0];
      return f;
   endfunction

   // Field value: inside the limits, at or next to a limit, zero, a width
   // extreme, or any bit pattern of the field
   function automatic int pick_value(int width, int lo, int hi);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return lo + int'($urandom_range(0, hi - lo));
      if (sel < 65) begin
         case ($urandom_range(0, 6))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1;
            3:       return hi + 1;
            4:       return 0;
            5:       return -(1 << (width - 1));
            default: return (1 << (width - 1)) - 1;
         endcase
      end
      return int'($urandom);
   endfunction

   function automatic icfe_pkg::req_type random_command();
      int          vel_h, trq_h;
      int unsigned vel_r, trq_r;
      icfe_pkg::req_type c;
      model_limits(cfg_model, vel_h, vel_r, trq_h, trq_r);
      c.pos_target = 18'(pick_value(18, -SCALE_POS_BOUND, SCALE_POS_BOUND));
      c.vel_target = 16'(pick_value(16, -vel_h, vel_h));
      c.stiffness  = 16'(pick_value(16, 0, SCALE_KP_MAX));
      c.damping    = 16'(pick_value(16, 0, SCALE_KD_MAX));
      c.torque_ff  = 16'(pick_value(16, -trq_h, trq_h));
      return c;
   endfunction

   task automatic add_row(int pos, int vel, int kp, int kd, int trq,
                          bit has_frame, icfe_pkg::rsp_type frame);
      directed_row_type row;
      row.cmd.pos_target = 18'(pos);
      row.cmd.vel_target = 16'(vel);
      row.cmd.stiffness  = 16'(kp);
      row.cmd.damping    = 16'(kd);
      row.cmd.torque_ff  = 16'(trq);
      row.has_frame      = has_frame;
      row.frame          = frame;
      directed_rows.push_back(row);
   endtask

   // Present one request and hold it until accepted; valid stays high
   task automatic push_command(icfe_pkg::req_type c, bit has_frame,
                               icfe_pkg::rsp_type frame);
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frame_expect_q.push_back(has_frame ? frame : encode_frame(c));
      cmds_sent++;
   endtask

   task automatic idle_cycles(int n);
      if (n == 0) return;
      req_valid <= 1'b0;
      req_data  <= random_command();
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_all_frames();
      req_valid <= 1'b0;
      while (frame_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         icfe_pkg::REG_MODEL_SELECT: cfg_model = data[1:0];
         icfe_pkg::REG_NODE_ID:      cfg_node  = data;
         icfe_pkg::REG_MODE_CODE:    cfg_mode  = data;
         default: ;
      endcase
   endtask

   // Bursts of requests with gaps of varied length between them
   task automatic run_random(int count);
      int sent;
      int burst;
      int sel;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            push_command(random_command(), 1'b0, '0);
            sent++;
         end
         sel = $urandom_range(0, 9);
         if (sel < 3) idle_cycles(0);
         else if (sel < 9) idle_cycles($urandom_range(1, 6));
         else idle_cycles($urandom_range(10, 30));
      end
   endtask

   // Response stall: a randomly chosen style, changed whenever its timer runs out
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_timer = $urandom_range(20, 200);
      end else begin
         stall_timer--;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            stall_tick++;
            rsp_stall <= (stall_tick % 3 == 0);
         end
      endcase
   end

   task automatic show_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
   endtask

   // Frame checker: every accepted frame against the oldest pending command
   always @(posedge clock) begin
      icfe_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_expect_q.size() == 0) begin
            error_count++;
            $display("%0t: frame with no pending request, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            want = frame_expect_q.pop_front();
            frames_checked++;
            if (rsp_data !== want) begin
               error_count++;
               show_field("frame_id", want.frame_id, rsp_data.frame_id);
               show_field("byte_0", 16'(want.byte_0), 16'(rsp_data.byte_0));
               show_field("byte_1", 16'(want.byte_1), 16'(rsp_data.byte_1));
               show_field("byte_2", 16'(want.byte_2), 16'(rsp_data.byte_2));
               show_field("byte_3", 16'(want.byte_3), 16'(rsp_data.byte_3));
               show_field("byte_4", 16'(want.byte_4), 16'(rsp_data.byte_4));
               show_field("byte_5", 16'(want.byte_5), 16'(rsp_data.byte_5));
               show_field("byte_6", 16'(want.byte_6), 16'(rsp_data.byte_6));
               show_field("byte_7", 16'(want.byte_7), 16'(rsp_data.byte_7));
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [1:0] phase_model [PHASE_COUNT];
      logic [7:0] wd;
      logic [7:0] node_val;
      logic [7:0] mode_val;

      phase_model = '{icfe_pkg::MODEL_1, icfe_pkg::MODEL_2, MODEL_SPARE,
                      icfe_pkg::MODEL_0, icfe_pkg::MODEL_2, icfe_pkg::MODEL_1,
                      MODEL_SPARE};

      // Corner commands under reset settings (model 0, id 0x0801)
      // at the field minimum and at or just below the lower limits: every code is zero
      add_row(-131072, -32768, -32768, -32768, -32768, 1'b1, FRAME_RST_ZERO);
      add_row(-51446, -15360, 0, 0, -3072, 1'b1, FRAME_RST_ZERO);
      add_row(-51447, -15361, -1, -1, -3073, 1'b1, FRAME_RST_ZERO);
      // at and above the upper limits: every code saturates
      add_row(131071, 32767, 32767, 32767, 32767, 1'b1, FRAME_RST_FULL);
      add_row(51446, 15360, 16000, 20480, 3072, 1'b1, FRAME_RST_FULL);
      add_row(51447, 15361, 16001, 20481, 3073, 1'b1, FRAME_RST_FULL);
      // near the limits, around zero, bit patterns, negative gains
      add_row(0, 0, 0, 0, 0, 1'b0, '0);
      add_row(-1, -1, -1, -1, -1, 1'b0, '0);
      add_row(1, 1, 1, 1, 1, 1'b0, '0);
      add_row(51445, 15359, 15999, 20479, 3071, 1'b0, '0);
      add_row(-51445, -15359, 1, 1, -3071, 1'b0, '0);
      add_row('h2AAAA, 'hAAAA, 'hAAAA, 'hAAAA, 'hAAAA, 1'b0, '0);
      add_row('h15555, 'h5555, 'h5555, 'h5555, 'h5555, 1'b0, '0);
      add_row(25000, -8000, 8000, 10240, -1500, 1'b0, '0);
      add_row(40000, 2000, -32768, -32768, 1000, 1'b0, '0);
      add_row(-40000, -2000, 32767, 32767, -1000, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_command(directed_rows[i].cmd, directed_rows[i].has_frame,
                      directed_rows[i].frame);
      run_random(PHASE_ITEMS);

      // New register settings only once every frame is out
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_all_frames();
         wd       = 8'($urandom_range(0, 255));
         wd[1:0]  = phase_model[p];
         node_val = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
         mode_val = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
         write_reg(icfe_pkg::REG_MODEL_SELECT, wd);
         write_reg(icfe_pkg::REG_NODE_ID, node_val);
         write_reg(icfe_pkg::REG_MODE_CODE, mode_val);
         csr_we <= 1'b0;
         run_random(PHASE_ITEMS);
      end

      wait_all_frames();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Encoded %0d impedance requests over %0d register settings, %0d frames checked",
               cmds_sent, PHASE_COUNT + 1, frames_checked);
      $display("Covered all four model selects, id bytes 0x00/0xFF, clamps and saturation");
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/icfe_pkg.sv
rtl/impedance_command_frame_encoder.sv
dv/impedance_command_frame_encoder_tb.sv
